// ===== sv/u8u16_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared result types, decode masks and surrogate constants.
// ---------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned CodeW         = 21;
  localparam int unsigned UnitW         = 16;
  localparam int unsigned QueueDepthDef = 4;

  // Lead byte classification.
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;
  localparam logic [7:0] Lead2Data  = 8'h1F;
  localparam logic [7:0] Lead3Data  = 8'h0F;
  localparam logic [7:0] Lead4Data  = 8'h07;

  // Surrogate pair construction.
  localparam logic [CodeW-1:0] SuppBase = 21'h10000;
  localparam logic [UnitW-1:0] SurrHigh = 16'hD800;
  localparam logic [UnitW-1:0] SurrLow  = 16'hDC00;

  // Number of continuation bytes still expected.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_ONE   = 2'd1,
    PEND_TWO   = 2'd2,
    PEND_THREE = 2'd3
  } pend_e;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             error;
    logic             last;
  } result_t;

  // Up to two results produced by one byte.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== sv/u8u16_decoder.sv =====
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the running sequence state and turns one byte into zero, one or
// two UTF-16 results, including the end-of-string error result.
// ---------------------------------------------------------------------------
module u8u16_decoder
  import u8u16_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  logic [CodeW-1:0] partial_q, partial_d;
  pend_e            pend_q, pend_d;
  logic             four_q, four_d;
  logic             drop_q, drop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pend_q    <= PEND_NONE;
      four_q    <= 1'b0;
      drop_q    <= 1'b0;
    end else if (step_i) begin
      partial_q <= partial_d;
      pend_q    <= pend_d;
      four_q    <= four_d;
      drop_q    <= drop_d;
    end
  end

  always_comb begin
    logic             done;
    logic             seq4;
    logic [CodeW-1:0] diff;
    logic [1:0]       n;
    partial_d = partial_q;
    pend_d    = pend_q;
    seq4      = four_q;
    drop_d    = drop_q;
    done      = 1'b0;
    push_o    = '0;

    if (!drop_q) begin
      if (pend_q != PEND_NONE) begin
        partial_d = {partial_q[CodeW-7:0], byte_i[5:0]};
        pend_d    = pend_e'(pend_q - 2'd1);
        done      = (pend_q == PEND_ONE);
      end else if ((byte_i & AsciiMask) == 8'h00) begin
        partial_d = CodeW'(byte_i);
        seq4      = 1'b0;
        done      = 1'b1;
      end else if ((byte_i & Lead2Mask) == Lead2Code) begin
        partial_d = CodeW'(byte_i & Lead2Data);
        pend_d    = PEND_ONE;
        seq4      = 1'b0;
      end else if ((byte_i & Lead3Mask) == Lead3Code) begin
        partial_d = CodeW'(byte_i & Lead3Data);
        pend_d    = PEND_TWO;
        seq4      = 1'b0;
      end else if ((byte_i & Lead4Mask) == Lead4Code) begin
        partial_d = CodeW'(byte_i & Lead4Data);
        pend_d    = PEND_THREE;
        seq4      = 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end

    // Supplementary code points are offset before splitting into halves.
    diff = partial_d - SuppBase;
    n    = 2'd0;
    if (done) begin
      if (seq4) begin
        push_o.r0.unit = SurrHigh | UnitW'(diff[19:10]);
        push_o.r1.unit = SurrLow | UnitW'(diff[9:0]);
        n = 2'd2;
      end else begin
        push_o.r0.unit = partial_d[UnitW-1:0];
        n = 2'd1;
      end
      seq4 = 1'b0;
    end
    four_d = seq4;

    if (last_i) begin
      if (drop_d || pend_d != PEND_NONE || n == 2'd0) begin
        push_o.r0 = '{unit: '0, error: 1'b1, last: 1'b1};
        n = 2'd1;
      end else if (n == 2'd2) begin
        push_o.r1.last = 1'b1;
      end else begin
        push_o.r0.last = 1'b1;
      end
      // The next string starts from a clean state.
      partial_d = '0;
      pend_d    = PEND_NONE;
      four_d    = 1'b0;
      drop_d    = 1'b0;
    end

    push_o.cnt = step_i ? n : 2'd0;
  end

endmodule

// ===== sv/u8u16_result_queue.sv =====
// ---------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands
// out one per transfer on the output channel.
// ---------------------------------------------------------------------------
module u8u16_result_queue
  import u8u16_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room2_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] Room2Lim = CntW'(Depth - 2);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  result_t          mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  wr1;
  logic             pop;

  assign wr1         = ptr_inc(wr_q);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (cnt_q <= Room2Lim);

  always_comb begin
    unique case (push_i.cnt)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = ptr_inc(wr1);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr1] <= push_i.r1;
    end
  end

endmodule

// ===== sv/utf8_to_utf16_transcoder_unit.sv =====
// A byte accepted into the input register is decoded once the result queue has room for two
// results; its results are registered in the queue, from which the output channel takes them.
// Throughput: one byte per cycle while the queue has room for two results; a four-byte
// sequence yields two results, which the result queue drains one per cycle unless stalled.
// Reset: asynchronous, clears the sequence state, the input valid flag and the queue pointers.
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Input register, sequence decoder and result queue.
// ---------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
  import u8u16_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [UnitW-1:0] unit_o,
  output logic             error_o,
  output logic             out_last_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       room2;
  logic       adv;
  logic       accept;
  push_t      push;
  result_t    res;

  // The held byte moves on only when the queue can take two results.
  assign adv        = vld_q && room2;
  assign in_stall_o = vld_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (adv) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  u8u16_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .push_o (push)
  );

  u8u16_result_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res)
  );

  assign unit_o     = res.unit;
  assign error_o    = res.error;
  assign out_last_o = res.last;

`ifndef SYNTH
  a_push_needs_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> adv)
    else $error("results pushed without a decoder step");

  a_error_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (unit_o == '0 && out_last_o))
    else $error("error result must carry a zero unit and end the string");

  a_pair_not_last_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (!push.r0.last && !push.r0.error && !push.r1.error))
    else $error("surrogate pair malformed");

  a_stall_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !room2) |=> (vld_q && $stable(byte_q) && $stable(last_q)))
    else $error("held byte lost while the queue was full");
`endif

endmodule

// ===== bench/tb_utf8_to_utf16_transcoder_unit.sv =====
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// A short table of directed bytes comes first. Random strings follow, most of
// them well formed and some broken. A byte-level decoder model predicts every unit
// that comes out. Both channels idle at random, and one long output hold-off
// fills the block so that it stalls its input.
// ---------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_unit;
  import u8u16_pkg::*;

  // Slowest correct run: about 1830 bytes, two units each, a receiver idling
  // about half the time, plus one long hold-off. CycleLimit leaves a wide
  // margin over that run.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned MaxPrinted  = 40;
  localparam push_t       NoRes       = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    push_t      want;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i   = 8'h00;
  logic             in_last_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [UnitW-1:0] unit_o;
  logic             error_o;
  logic             out_last_o;

  // Decoder state of the predictor.
  logic [CodeW-1:0] dec_code = '0;
  pend_e            dec_pend = PEND_NONE;
  logic             dec_four = 1'b0;
  logic             dec_drop = 1'b0;

  result_t          unit_q [$];
  result_t          head_unit;
  dir_row_t         dir_tab [26];

  int unsigned      snd_idle   = 0;
  int unsigned      rcv_idle   = 0;
  logic             hold_go    = 1'b0;
  logic             stall_hold = 1'b0;
  int unsigned      cycle_cnt  = 0;
  int unsigned      mism_cnt   = 0;
  int unsigned      byte_cnt   = 0;
  int unsigned      str_cnt    = 0;
  int unsigned      unit_cnt   = 0;
  int unsigned      err_end_cnt = 0;
  int unsigned      phase_end;

  utf8_to_utf16_transcoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .unit_o      (unit_o),
    .error_o     (error_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic push_t mk1(logic [UnitW-1:0] u, logic err, logic lst);
    push_t p;
    p = '0;
    p.cnt = 2'd1;
    p.r0.unit = u;
    p.r0.error = err;
    p.r0.last = lst;
    return p;
  endfunction

  function automatic push_t mk2(logic [UnitW-1:0] hi, logic [UnitW-1:0] lo);
    push_t p;
    p = '0;
    p.cnt = 2'd2;
    p.r0.unit = hi;
    p.r1.unit = lo;
    p.r1.last = 1'b1;
    return p;
  endfunction

  // Advances the decoder by one byte and returns the units that byte yields.
  function automatic push_t decode_utf8_byte(logic [7:0] b, logic lst);
    push_t            res;
    logic             done;
    logic [CodeW-1:0] off;
    res = '0;
    done = 1'b0;
    if (!dec_drop) begin
      if (dec_pend != PEND_NONE) begin
        // Continuation bytes are merged without a look at their top bits.
        dec_code = {dec_code[CodeW-7:0], b[5:0]};
        dec_pend = pend_e'(dec_pend - 2'd1);
        done = (dec_pend == PEND_NONE);
      end else if ((b & AsciiMask) == 8'h00) begin
        dec_code = CodeW'(b);
        dec_four = 1'b0;
        done = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Code) begin
        dec_code = CodeW'(b & Lead2Data);
        dec_pend = PEND_ONE;
        dec_four = 1'b0;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        dec_code = CodeW'(b & Lead3Data);
        dec_pend = PEND_TWO;
        dec_four = 1'b0;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        dec_code = CodeW'(b & Lead4Data);
        dec_pend = PEND_THREE;
        dec_four = 1'b1;
      end else begin
        dec_drop = 1'b1;
      end
      if (done) begin
        if (dec_four) begin
          // Codes below the supplementary base wrap; only 20 bits are kept.
          off = dec_code - SuppBase;
          res.cnt = 2'd2;
          res.r0.unit = SurrHigh | UnitW'(off[19:10]);
          res.r1.unit = SurrLow | UnitW'(off[9:0]);
        end else begin
          res.cnt = 2'd1;
          res.r0.unit = dec_code[UnitW-1:0];
        end
        dec_four = 1'b0;
      end
    end
    if (lst) begin
      if (dec_drop || dec_pend != PEND_NONE || res.cnt == 2'd0) begin
        res = mk1('0, 1'b1, 1'b1);
      end else if (res.cnt == 2'd2) begin
        res.r1.last = 1'b1;
      end else begin
        res.r0.last = 1'b1;
      end
      dec_code = '0;
      dec_pend = PEND_NONE;
      dec_four = 1'b0;
      dec_drop = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [UnitW-1:0] got, logic [UnitW-1:0] want);
    if (mism_cnt < MaxPrinted)
      $display("mismatch, cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    mism_cnt++;
  endtask

  // Offers one byte and waits for its transfer. Typed rows replace the
  // predicted units, though the decoder still steps.
  task automatic send_byte(logic [7:0] b, logic lst, logic typed, push_t want);
    push_t pr;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'($urandom);
      in_last_i  <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pr = decode_utf8_byte(b, lst);
    if (typed) pr = want;
    if (pr.cnt >= 2'd1) unit_q.push_back(pr.r0);
    if (pr.cnt == 2'd2) unit_q.push_back(pr.r1);
    byte_cnt++;
    if (lst) str_cnt++;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(15) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // One random string: a few code points of random length, now and then
  // broken by a stray byte, a cut-off tail or plain noise.
  task automatic send_string();
    logic [7:0]  bq [$];
    int unsigned ncp;
    int unsigned flaw;
    ncp = $urandom_range(5, 1);
    for (int unsigned i = 0; i < ncp; i++) begin
      case ($urandom_range(3, 0))
        0: bq.push_back({1'b0, 7'($urandom)});
        1: begin
          bq.push_back({3'b110, 5'($urandom)});
          bq.push_back(cont_byte());
        end
        2: begin
          bq.push_back({4'b1110, 4'($urandom)});
          repeat (2) bq.push_back(cont_byte());
        end
        default: begin
          bq.push_back({5'b11110, 3'($urandom)});
          repeat (3) bq.push_back(cont_byte());
        end
      endcase
    end
    flaw = $urandom_range(9, 0);
    if (flaw == 0) begin
      bq[$urandom_range(bq.size() - 1, 0)] = 8'($urandom);
    end else if (flaw == 1 && bq.size() > 1) begin
      void'(bq.pop_back());
    end else if (flaw == 2) begin
      bq.delete();
      repeat ($urandom_range(4, 1)) bq.push_back(8'($urandom));
    end
    foreach (bq[i]) send_byte(bq[i], (i == bq.size() - 1), 1'b0, NoRes);
  endtask

  // Output side: check each transfer against the oldest expected unit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        unit_cnt++;
        if (error_o) err_end_cnt++;
        if (unit_q.size() == 0) begin
          report_mismatch("unexpected unit", unit_o, '0);
        end else begin
          head_unit = unit_q.pop_front();
          if (unit_o !== head_unit.unit) report_mismatch("unit", unit_o, head_unit.unit);
          if (error_o !== head_unit.error)
            report_mismatch("error", UnitW'(error_o), UnitW'(head_unit.error));
          if (out_last_o !== head_unit.last)
            report_mismatch("out_last", UnitW'(out_last_o), UnitW'(head_unit.last));
        end
      end
      out_stall_i <= stall_hold || ($urandom_range(99) < rcv_idle);
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d units outstanding", cycle_cnt, unit_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, mk1(16'h0000, 1'b0, 1'b0)},
      '{8'h7F, 1'b1, 1'b1, mk1(16'h007F, 1'b0, 1'b1)},
      '{8'hC2, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b1, 1'b0, NoRes},
      '{8'hE2, 1'b0, 1'b1, NoRes},
      '{8'h82, 1'b0, 1'b1, NoRes},
      '{8'hAC, 1'b1, 1'b1, mk1(16'h20AC, 1'b0, 1'b1)},
      '{8'hF0, 1'b0, 1'b1, NoRes},
      '{8'h9F, 1'b0, 1'b1, NoRes},
      '{8'h98, 1'b0, 1'b1, NoRes},
      '{8'h80, 1'b1, 1'b1, mk2(16'hD83D, 16'hDE00)},
      '{8'hF0, 1'b0, 1'b0, NoRes},
      '{8'h80, 1'b0, 1'b0, NoRes},
      '{8'h80, 1'b0, 1'b0, NoRes},
      '{8'h80, 1'b1, 1'b0, NoRes},
      '{8'hF7, 1'b0, 1'b0, NoRes},
      '{8'hBF, 1'b0, 1'b0, NoRes},
      '{8'hBF, 1'b0, 1'b0, NoRes},
      '{8'hBF, 1'b1, 1'b0, NoRes},
      '{8'h80, 1'b1, 1'b1, mk1(16'h0000, 1'b1, 1'b1)},
      '{8'hFF, 1'b1, 1'b1, mk1(16'h0000, 1'b1, 1'b1)},
      '{8'hE2, 1'b0, 1'b1, NoRes},
      '{8'h82, 1'b1, 1'b1, mk1(16'h0000, 1'b1, 1'b1)},
      '{8'h41, 1'b0, 1'b1, mk1(16'h0041, 1'b0, 1'b0)},
      '{8'h80, 1'b0, 1'b1, NoRes},
      '{8'h42, 1'b1, 1'b1, mk1(16'h0000, 1'b1, 1'b1)}
    };

    repeat (5) @(posedge clk_i);
    rst_ni   <= 1'b1;
    snd_idle <= 7;
    rcv_idle <= 48;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        snd_idle <= 48;
        rcv_idle <= 7;
      end else if (ph == 2) begin
        snd_idle <= 0;
        rcv_idle <= 0;
        hold_go  <= 1'b1;
      end
      phase_end = byte_cnt + PhaseBytes;
      while (byte_cnt < phase_end) send_string();
    end

    in_valid_i <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings under three idling mixes and one long hold-off.",
             byte_cnt, str_cnt);
    $display("Checked %0d units, %0d of them error ends; %0d mismatches.",
             unit_cnt, err_end_cnt, mism_cnt);
    if (mism_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
